// ===== hw/rtl/icmp_echo_request_builder_macros.svh =====
// assertion macros for the icmp echo request builder
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef ICMP_ECHO_REQUEST_BUILDER_MACROS_SVH
`define ICMP_ECHO_REQUEST_BUILDER_MACROS_SVH

// same-cycle implication, checked out of reset
`define IERB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define IERB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ierb_pkg.sv =====
// shared types and constants for the icmp echo request builder
// no dependencies
`default_nettype none

package ierb_pkg;

  // icmp echo request header
  localparam logic [7:0] EchoType = 8'd8;
  localparam logic [7:0] EchoCode = 8'd0;
  localparam int unsigned HdrBytes = 8;

  // field widths
  localparam int unsigned IdxW = 7;
  localparam int unsigned RawSumW = 25;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_ECHO_ID     = 2'd0,
    REG_PAYLOAD_LEN = 2'd1,
    REG_FILL        = 2'd2
  } ierb_reg_e;

  // per-packet header fields, payload length already clamped
  typedef struct packed {
    logic [15:0] echo_id;
    logic [15:0] seq;
    logic [7:0]  fill;
    logic [7:0]  pay_len;
  } ierb_hdr_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ierb_csum.sv =====
// unfolded one's-complement sum of a whole echo request packet
// depends on ierb_pkg
`default_nettype none

module ierb_csum (
  input  ierb_pkg::ierb_hdr_t               hdr_i,
  output logic [ierb_pkg::RawSumW-1:0]      raw_sum_o
);
  import ierb_pkg::*;

  logic [6:0]  pairs;
  logic [15:0] fill_word;
  logic [22:0] pair_sum;
  logic [15:0] odd_word;

  // payload words: every full pair is {fill, fill}, an odd tail byte is padded
  assign pairs     = hdr_i.pay_len[7:1];
  assign fill_word = {hdr_i.fill, hdr_i.fill};
  assign pair_sum  = 23'(pairs) * 23'(fill_word);
  assign odd_word  = hdr_i.pay_len[0] ? {hdr_i.fill, 8'h00} : 16'h0000;

  // header words with the checksum field counted as zero
  assign raw_sum_o = RawSumW'({EchoType, EchoCode})
                   + RawSumW'({hdr_i.echo_id[7:0], hdr_i.echo_id[15:8]})
                   + RawSumW'(hdr_i.seq)
                   + RawSumW'(pair_sum)
                   + RawSumW'(odd_word);

endmodule

`default_nettype wire

// ===== hw/rtl/icmp_echo_request_builder.sv =====
// top level of the icmp echo request builder: apb registers, job stage, byte emitter
// depends on ierb_pkg, ierb_csum and icmp_echo_request_builder_macros.svh
`default_nettype none
// Usage
//   A request transaction is taken at a rising edge with start high and busy low;
//   sequence_req_i carries the sequence number. The block then sends one ICMP
//   echo request, one byte per cycle on packet_byte_o, each marked by
//   result_strobe_o for one cycle, with byte_index_o counting from 0 and
//   last_byte_o high on the final byte.
//   Packet length is 8 + min(payload_length, MAX_PACKET_BYTES - 8) bytes, 64 at
//   reset values. An accepted request passes the job register, then the emitter,
//   then the output register; it waits in the job register while a packet is in flight.
//   The single byte emitter paces the requests; a following request is taken
//   while the current packet is still going out, so packets leave with no gap
//   between them. busy stays high while one request waits behind the packet
//   in flight.
//   The checksum is summed in the job stage (one small multiply for the
//   repeated fill words) and folded when the emitter loads the job.
//   Registers echo_id (0x0), payload_length (0x4), fill_pattern (0x8) are to be written
//   over APB only while the block is idle; the user must keep to this, the block does not
//   enforce it. Reset gives echo_id 0, payload_length 56, fill_pattern 0 and drops any
//   request in progress. The receiver cannot stall: every strobed byte counts as delivered.

module icmp_echo_request_builder #(
  parameter int unsigned MAX_PACKET_BYTES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        start,
  output logic        busy,
  input  logic [15:0] sequence_req_i,
  // byte stream
  output logic        result_strobe_o,
  output logic [7:0]  packet_byte_o,
  output logic [ierb_pkg::IdxW-1:0] byte_index_o,
  output logic        last_byte_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ierb_pkg::*;

  `include "icmp_echo_request_builder_macros.svh"

  localparam logic [7:0] MaxPayload = 8'(MAX_PACKET_BYTES - HdrBytes);

  // configuration registers
  logic [15:0] echo_id_q;
  logic [7:0]  pay_len_q;
  logic [7:0]  fill_q;
  logic        cfg_wr;

  // job stage
  logic                s1_valid_q, s1_valid_d;
  ierb_hdr_t           s1_hdr_q, s1_hdr_d;
  logic [RawSumW-1:0]  s1_raw_q, raw_sum;

  // emitter
  logic                em_valid_q, em_valid_d;
  ierb_hdr_t           em_hdr_q;
  logic [15:0]         em_csum_q, csum_d;
  logic [IdxW-1:0]     em_idx_q, em_idx_d;
  logic [IdxW-1:0]     em_last_idx;
  logic                em_is_last, em_free, load, accept;
  logic [7:0]          byte_sel;

  // fold of the raw sum
  logic [16:0] fold1;
  logic [15:0] fold2;

  // output register
  logic            strobe_q;
  logic [7:0]      byte_q;
  logic [IdxW-1:0] idx_q;
  logic            last_q;

  // apb write and read
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      echo_id_q <= 16'd0;
      pay_len_q <= 8'd56;
      fill_q    <= 8'd0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_ECHO_ID:     echo_id_q <= pwdata[15:0];
        REG_PAYLOAD_LEN: pay_len_q <= pwdata[7:0];
        REG_FILL:        fill_q    <= pwdata[7:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ECHO_ID:     prdata = {16'd0, echo_id_q};
      REG_PAYLOAD_LEN: prdata = {24'd0, pay_len_q};
      REG_FILL:        prdata = {24'd0, fill_q};
      default:         prdata = 32'd0;
    endcase
  end

  // handshake: the job slot frees when the emitter takes its contents
  assign em_last_idx = IdxW'(em_hdr_q.pay_len + 8'd7);
  assign em_is_last  = (em_idx_q == em_last_idx);
  assign em_free     = !em_valid_q || em_is_last;
  assign load        = s1_valid_q && em_free;
  assign busy        = s1_valid_q && !em_free;
  assign accept      = start && !busy;

  // job stage: clamp length, sum the packet
  always_comb begin
    s1_hdr_d.echo_id = echo_id_q;
    s1_hdr_d.seq     = sequence_req_i;
    s1_hdr_d.fill    = fill_q;
    s1_hdr_d.pay_len = (pay_len_q > MaxPayload) ? MaxPayload : pay_len_q;
  end

  ierb_csum u_csum (
    .hdr_i     (s1_hdr_d),
    .raw_sum_o (raw_sum)
  );

  always_comb begin
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (load) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_hdr_q <= s1_hdr_d;
      s1_raw_q <= raw_sum;
    end
  end

  // end-around carry fold and inversion
  assign fold1  = {1'b0, s1_raw_q[15:0]} + 17'(s1_raw_q[RawSumW-1:16]);
  assign fold2  = fold1[15:0] + 16'(fold1[16]);
  assign csum_d = ~fold2;

  // emitter: walk the byte index of the current packet
  always_comb begin
    em_valid_d = em_valid_q;
    em_idx_d   = em_idx_q;
    if (load) begin
      em_valid_d = 1'b1;
      em_idx_d   = '0;
    end else if (em_valid_q) begin
      if (em_is_last) begin
        em_valid_d = 1'b0;
      end else begin
        em_idx_d = em_idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      em_valid_q <= 1'b0;
      em_idx_q   <= '0;
    end else begin
      em_valid_q <= em_valid_d;
      em_idx_q   <= em_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      em_hdr_q  <= s1_hdr_q;
      em_csum_q <= csum_d;
    end
  end

  // byte select by position
  always_comb begin
    case (em_idx_q)
      IdxW'(0): byte_sel = EchoType;
      IdxW'(1): byte_sel = EchoCode;
      IdxW'(2): byte_sel = em_csum_q[15:8];
      IdxW'(3): byte_sel = em_csum_q[7:0];
      IdxW'(4): byte_sel = em_hdr_q.echo_id[7:0];
      IdxW'(5): byte_sel = em_hdr_q.echo_id[15:8];
      IdxW'(6): byte_sel = em_hdr_q.seq[15:8];
      IdxW'(7): byte_sel = em_hdr_q.seq[7:0];
      default:  byte_sel = em_hdr_q.fill;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= em_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_sel;
    idx_q  <= em_idx_q;
    last_q <= em_is_last;
  end

  assign result_strobe_o = strobe_q;
  assign packet_byte_o   = byte_q;
  assign byte_index_o    = idx_q;
  assign last_byte_o     = last_q;

  // checks
  `IERB_ASSERT_NOW(a_idx_step, result_strobe_o && (byte_index_o != '0), $past(result_strobe_o) && (byte_index_o == IdxW'($past(byte_index_o) + IdxW'(1))), "byte index skipped")
  `IERB_ASSERT_NEXT(a_no_gap, result_strobe_o && !last_byte_o, result_strobe_o, "packet stream broke before last byte")
  `IERB_ASSERT_NEXT(a_new_pkt, result_strobe_o && last_byte_o, !result_strobe_o || (byte_index_o == '0), "packet did not restart at index zero")
  `IERB_ASSERT_NEXT(a_job_held, start && !busy, s1_valid_q, "accepted request not held in job stage")

endmodule

`default_nettype wire

// ===== test/icmp_echo_request_builder_tb.sv =====
// self-checking testbench for the icmp echo request builder
// depends on ierb_pkg and icmp_echo_request_builder; predicts every packet byte
// including the one's-complement checksum and checks the byte stream in order

module icmp_echo_request_builder_tb;
  import ierb_pkg::*;

  localparam int unsigned MaxPacketBytes = 64;
  localparam int unsigned MaxPayload     = MaxPacketBytes - HdrBytes;
  localparam int unsigned SettleCycles   = 4;
  localparam int unsigned WatchdogLimit  = 2000;
  localparam int unsigned RandomPhases   = 12;
  localparam int unsigned ItemsPerPhase  = 20;
  // address one past the last register, writes there must be ignored
  localparam logic [3:0]  UnusedRegAddr  = 4'hC;

  // one expected byte of the outgoing packet
  typedef struct packed {
    logic [7:0]      data;
    logic [IdxW-1:0] index;
    logic            last;
  } echo_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] seq_req = '0;
  logic        result_strobe;
  logic [7:0]  packet_byte;
  logic [IdxW-1:0] byte_index;
  logic        last_byte;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // shadow copy of the configuration registers
  logic [15:0] cfg_echo_id  = 16'd0;
  logic [7:0]  cfg_pay_len  = 8'd56;
  logic [7:0]  cfg_fill     = 8'd0;

  logic [15:0] pending_seqs[$];
  echo_byte_t  expected_bytes[$];

  bit          gaps_enabled = 1'b1;
  int unsigned gap_left = 0;
  int unsigned fail_count = 0;
  int unsigned requests_sent = 0;
  int unsigned bytes_checked = 0;
  int unsigned settings_used = 0;
  int unsigned quiet_cycles = 0;

  icmp_echo_request_builder #(
    .MAX_PACKET_BYTES(MaxPacketBytes)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .sequence_req_i (seq_req),
    .result_strobe_o(result_strobe),
    .packet_byte_o  (packet_byte),
    .byte_index_o   (byte_index),
    .last_byte_o    (last_byte),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #10 clk_i = ~clk_i;

  // build the echo request for one sequence number and queue its bytes
  function automatic void predict_echo_packet(input logic [15:0] seq);
    logic [7:0]  pkt[MaxPacketBytes];
    int unsigned total;
    logic [31:0] sum;
    logic [15:0] csum;
    echo_byte_t  eb;
    total = HdrBytes + ((cfg_pay_len > MaxPayload) ? MaxPayload : cfg_pay_len);
    pkt[0] = EchoType;
    pkt[1] = EchoCode;
    pkt[2] = 8'h00;
    pkt[3] = 8'h00;
    pkt[4] = cfg_echo_id[7:0];
    pkt[5] = cfg_echo_id[15:8];
    pkt[6] = seq[15:8];
    pkt[7] = seq[7:0];
    for (int i = HdrBytes; i < total; i++) pkt[i] = cfg_fill;
    // big-endian words, odd tail padded with a zero low byte
    sum = '0;
    for (int i = 0; i < total; i += 2)
      sum += {16'h0, pkt[i], ((i + 1 < total) ? pkt[i + 1] : 8'h00)};
    while (sum[31:16] != 16'h0) sum = {16'h0, sum[15:0]} + {16'h0, sum[31:16]};
    csum = ~sum[15:0];
    pkt[2] = csum[15:8];
    pkt[3] = csum[7:0];
    for (int i = 0; i < total; i++) begin
      eb.data  = pkt[i];
      eb.index = i[IdxW-1:0];
      eb.last  = (i + 1 == total);
      expected_bytes.push_back(eb);
    end
  endfunction

  // request driver: one transaction per pending sequence number, random gaps
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_echo_packet(seq_req);
        requests_sent++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_seqs.size() > 0) begin
          start   <= 1'b1;
          seq_req <= pending_seqs.pop_front();
          if (gaps_enabled && $urandom_range(0, 4) == 0)
            gap_left = $urandom_range(1, 14);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // byte stream monitor, compares against the oldest expected byte
  always @(posedge clk_i) begin
    if (rst_ni && result_strobe) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected packet byte %0h at index %0d", packet_byte, byte_index);
        fail_count++;
      end else begin
        echo_byte_t eb;
        eb = expected_bytes.pop_front();
        bytes_checked++;
        if (packet_byte !== eb.data) begin
          $error("packet_byte mismatch: expected %0h, actual %0h", eb.data, packet_byte);
          fail_count++;
        end
        if (byte_index !== eb.index) begin
          $error("byte_index mismatch: expected %0d, actual %0d", eb.index, byte_index);
          fail_count++;
        end
        if (last_byte !== eb.last) begin
          $error("last_byte mismatch: expected %0b, actual %0b", eb.last, last_byte);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction of any kind
  always @(posedge clk_i) begin
    if ((start && !busy) || result_strobe || (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("timeout after %0d quiet cycles", quiet_cycles);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // apb register write, shadow copy follows the register map
  task automatic write_reg(input logic [3:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr[1:0] == 2'b00) begin
      case (ierb_reg_e'(addr[3:2]))
        REG_ECHO_ID:     cfg_echo_id = data[15:0];
        REG_PAYLOAD_LEN: cfg_pay_len = data[7:0];
        REG_FILL:        cfg_fill    = data[7:0];
        default:         ;
      endcase
    end
  endtask

  task automatic set_config(input logic [31:0] id, input logic [31:0] len,
                            input logic [31:0] fill);
    write_reg({REG_ECHO_ID, 2'b00}, id);
    write_reg({REG_PAYLOAD_LEN, 2'b00}, len);
    write_reg({REG_FILL, 2'b00}, fill);
    settings_used++;
  endtask

  // hold until every request is out and every byte has arrived
  task automatic wait_all_done();
    @(negedge clk_i);
    while (pending_seqs.size() != 0 || start || expected_bytes.size() != 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] rand_len;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset values: 56-byte zero payload, full 64-byte packet
    settings_used++;
    pending_seqs = '{16'h0000, 16'hFFFF, 16'h8000, 16'h0001};
    wait_all_done();

    // all-ones id and fill, oversized payload gets clamped
    set_config(32'h0000_FFFF, 32'h0000_00FF, 32'h0000_00FF);
    pending_seqs = '{16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555};
    wait_all_done();

    // header-only packet, excess bits on every register write
    set_config(32'hABCD_1234, 32'hFFFF_FF00, 32'h5A5A_5AA5);
    write_reg(UnusedRegAddr, 32'hFFFF_FFFF);
    pending_seqs = '{16'h7FFF, 16'h0000, 16'hFFFF};
    wait_all_done();

    // odd length: one payload byte, nine-byte packet
    set_config(32'h0000_8001, 32'h0000_0001, 32'h0000_00FF);
    pending_seqs = '{16'h1234, 16'hFFFF};
    wait_all_done();

    // odd length at the upper end, 63 bytes
    set_config(32'h0000_0000, 32'h0000_0037, 32'h0000_0080);
    pending_seqs = '{16'hFEDC, 16'h0000};
    wait_all_done();

    // exactly full, then one past the clamp point
    set_config(32'h0000_FFFF, 32'h0000_0038, 32'h0000_0001);
    pending_seqs = '{16'hFFFF};
    wait_all_done();
    set_config(32'h0000_00FF, 32'h0000_0039, 32'h0000_00FE);
    pending_seqs = '{16'hFF00, 16'h00FF};
    wait_all_done();

    // random settings with back-to-back and gapped requests
    for (int p = 0; p < RandomPhases; p++) begin
      case ($urandom_range(0, 9))
        0:       rand_len = $urandom_range(MaxPayload + 1, 255);
        1:       rand_len = 32'd0;
        2:       rand_len = MaxPayload;
        default: rand_len = $urandom_range(1, 24);
      endcase
      set_config($urandom(),
                 {16'($urandom_range(0, 65535)), 8'h00, rand_len[7:0]},
                 $urandom());
      if (p == RandomPhases - 1) gaps_enabled = 1'b0;
      for (int k = 0; k < ItemsPerPhase; k++)
        pending_seqs.push_back(16'($urandom_range(0, 65535)));
      wait_all_done();
    end

    $display("covered %0d echo requests and %0d packet bytes", requests_sent, bytes_checked);
    $display("over %0d register settings incl. empty, odd and clamped payloads", settings_used);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
